/* rtl/musc_pkg.sv */
// Package for the minimal uncovered set check: request and result types,
// register indexes, function codes and sequencer states. No dependencies.
`default_nettype none

package musc_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SUPPORT = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST   = 9'd256;
  localparam logic [CFG_DATA_W-1:0] MIN_SUPPORT_RST = 9'd1;

  // Function codes of an input request.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Input request: a row write or a column-set query.
  typedef struct packed {
    logic        func;
    logic [7:0]  row_index;
    logic [63:0] row_bits;
    logic [63:0] item_mask;
  } in_item_t;

  // Result of one query.
  typedef struct packed {
    logic support_reached;
    logic uncovered;
    logic minimal_uncovered;
  } out_item_t;

  // Query sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/minimal_uncovered_set_check.sv */
// A query reads min(row_count, MAX_ROWS) rows, one row per cycle through the single read port
// of the row memory, then passes the drain and done states; a still stalled earlier result
// can hold it back in the done state before its result is loaded.
// Throughput: one write per cycle while no query is in flight.
// The input side stalls while a query is walking the rows and until its result is loaded.
// Reset (synchronous, rst_n low) clears the sequencer, the result valid and the registers
// to row_count 256 and min_support 1; the row memory is not cleared.
`default_nettype none

module minimal_uncovered_set_check #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 64
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // Input request channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  musc_pkg::in_item_t              in_data,
  // Result channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output musc_pkg::out_item_t             out_data,
  // Configuration write channel
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [musc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [musc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Address, row counter and comparison widths.
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int XW = (CW > musc_pkg::CFG_DATA_W) ? CW : musc_pkg::CFG_DATA_W;

  // Row memory, undefined until written.
  logic [MAX_COLS-1:0] mem [MAX_ROWS];

  musc_pkg::state_t state_r, state_nxt;

  logic [musc_pkg::CFG_DATA_W-1:0] row_count_r;
  logic [musc_pkg::CFG_DATA_W-1:0] min_support_r;

  logic [MAX_COLS-1:0] mask_r;
  logic [MAX_COLS-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       rows_lim_r;
  logic [CW-1:0]       hits_r;
  logic [MAX_COLS-1:0] drop_ok_r;

  logic                out_valid_r;
  musc_pkg::out_item_t out_data_r;

  logic                in_acc;
  logic                wr_en;
  logic                rd_en;
  logic                start_q;
  logic                out_load;
  logic [CW-1:0]       rows_lim;
  logic [MAX_COLS-1:0] missing;
  logic                miss_none;
  logic                miss_one;
  logic                mask_one;
  musc_pkg::out_item_t res;

  assign in_stall  = (state_r != musc_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A write to an index beyond the memory is dropped.
  assign wr_en = in_acc && (in_data.func == musc_pkg::FUNC_WRITE)
                 && (32'(in_data.row_index) < MAX_ROWS);

  // Rows examined: the programmed count, clamped to the memory depth.
  always_comb begin
    if (XW'(row_count_r) > XW'(MAX_ROWS)) begin
      rows_lim = CW'(MAX_ROWS);
    end else begin
      rows_lim = CW'(row_count_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= musc_pkg::ROW_COUNT_RST;
      min_support_r <= musc_pkg::MIN_SUPPORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        musc_pkg::REG_ROW_COUNT:   row_count_r   <= cfg_data;
        musc_pkg::REG_MIN_SUPPORT: min_support_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Row memory: one write port for row requests, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_data.row_index)] <= in_data.row_bits[MAX_COLS-1:0];
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  // Classify the row just read: holds the whole set, or misses exactly one column.
  assign missing   = mask_r & ~rd_data_r;
  assign miss_none = (missing == '0);
  assign miss_one  = !miss_none && ((missing & (missing - MAX_COLS'(1))) == '0);
  assign mask_one  = (mask_r != '0) && ((mask_r & (mask_r - MAX_COLS'(1))) == '0);

  // Flags of the finished query.
  always_comb begin
    res.support_reached   = (XW'(hits_r) >= XW'(min_support_r));
    res.uncovered         = (hits_r == '0);
    res.minimal_uncovered = (hits_r == '0) && (mask_one || (drop_ok_r == mask_r));
  end

  // Sequencer: next state and control.
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    start_q   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      musc_pkg::S_IDLE: begin
        if (in_acc && (in_data.func == musc_pkg::FUNC_QUERY)) begin
          start_q   = 1'b1;
          state_nxt = (rows_lim == '0) ? musc_pkg::S_DRAIN : musc_pkg::S_SCAN;
        end
      end
      musc_pkg::S_SCAN: begin
        rd_en = 1'b1;
        if (CW'(idx_r + CW'(1)) == rows_lim_r) begin
          state_nxt = musc_pkg::S_DRAIN;
        end
      end
      musc_pkg::S_DRAIN: begin
        state_nxt = musc_pkg::S_DONE;
      end
      musc_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = musc_pkg::S_IDLE;
        end
      end
      default: state_nxt = musc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= musc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan datapath: read index, query capture and accumulation of the row just read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
    if (start_q) begin
      mask_r     <= in_data.item_mask[MAX_COLS-1:0];
      rows_lim_r <= rows_lim;
      idx_r      <= '0;
      hits_r     <= '0;
      drop_ok_r  <= '0;
    end else begin
      if (rd_en) begin
        idx_r <= CW'(idx_r + CW'(1));
      end
      if (rd_vld_r) begin
        if (miss_none) begin
          hits_r <= CW'(hits_r + CW'(1));
        end else if (miss_one) begin
          drop_ok_r <= drop_ok_r | missing;
        end
      end
    end
  end

  // Result register: holds a result until the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  // A new result only appears when a query has finished its scan.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == musc_pkg::S_DONE))
    else $error("result loaded outside the done state");

  // The read index stays inside the rows examined by this query.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == musc_pkg::S_SCAN) |-> (idx_r < rows_lim_r))
    else $error("scan index beyond the examined rows");

  // Read data is only marked valid right after a scan cycle.
  a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == musc_pkg::S_SCAN))
    else $error("read data valid without a scan cycle");

  // No query counts more matching rows than it examined.
  a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == musc_pkg::S_DONE) |-> (hits_r <= rows_lim_r))
    else $error("hit count exceeds examined rows");

  // A pending result is never overwritten while the far side stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire
